FILE: hdl/backslash_escape_decoder_unit_macros.svh
// Assertion macros used by the checker file of the escape decoder.
`ifndef BACKSLASH_ESCAPE_DECODER_UNIT_MACROS_SVH
`define BACKSLASH_ESCAPE_DECODER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define BSED_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define BSED_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/bsed_pkg.sv
// Shared types and constants of the backslash escape decoder.
package bsed_pkg;

    // Most bytes that one request can produce.
    localparam int OUT_MAX = 5;
    // Width of a burst byte count (0 to OUT_MAX).
    localparam int CNT_W = $clog2(OUT_MAX + 1);
    // Width of an index into the bytes of a burst.
    localparam int IDX_W = $clog2(OUT_MAX);
    // Entries of the queue between front and back; a power of two.
    localparam int QUEUE_DEPTH = 4;

    // One raw input request.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_string;
    } t_in_item;

    // One decoded output byte.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
    } t_out_item;

    // All bytes that one request produces, oldest in entry 0.
    typedef struct packed {
        logic [OUT_MAX-1:0][7:0] bytes;
        logic [CNT_W-1:0]        count;
    } t_burst;

endpackage

FILE: hdl/bsed_front.sv
// Front end: parses one raw byte per cycle while input is accepted and builds the burst of bytes it produces.
module bsed_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  bsed_pkg::t_in_item i_item,
    output bsed_pkg::t_burst  o_burst,
    output logic              o_has
);

    // Parser state codes.
    localparam logic [3:0] MODE_PLAIN  = 4'd0;
    localparam logic [3:0] MODE_BSL    = 4'd1;
    localparam logic [3:0] MODE_OPEN   = 4'd2;
    localparam logic [3:0] MODE_DIGITS = 4'd3;
    localparam logic [3:0] MODE_CLOSE  = 4'd4;
    localparam logic [3:0] MODE_LA0    = 4'd5;
    localparam logic [3:0] MODE_LA1    = 4'd6;
    localparam logic [3:0] MODE_LA2    = 4'd7;
    localparam logic [3:0] MODE_LA3    = 4'd8;
    localparam logic [3:0] MODE_LOW    = 4'd9;

    // Character codes.
    localparam logic [7:0] CHR_NUL    = 8'h00;
    localparam logic [7:0] CHR_BSL    = 8'h5C;
    localparam logic [7:0] CHR_LBRACE = 8'h7B;
    localparam logic [7:0] CHR_RBRACE = 8'h7D;
    localparam logic [7:0] CHR_QMARK  = 8'h3F;
    localparam logic [7:0] CHR_LC_B   = 8'h62;
    localparam logic [7:0] CHR_LC_E   = 8'h65;
    localparam logic [7:0] CHR_LC_F   = 8'h66;
    localparam logic [7:0] CHR_LC_N   = 8'h6E;
    localparam logic [7:0] CHR_LC_R   = 8'h72;
    localparam logic [7:0] CHR_LC_T   = 8'h74;
    localparam logic [7:0] CHR_LC_X   = 8'h78;
    localparam logic [7:0] CHR_LC_U   = 8'h75;
    localparam logic [7:0] CHR_UC_U   = 8'h55;
    localparam logic [7:0] CHR_LC_D   = 8'h64;
    localparam logic [7:0] CHR_UC_D   = 8'h44;
    localparam logic [7:0] CHR_BS     = 8'h08;
    localparam logic [7:0] CHR_ESC    = 8'h1B;
    localparam logic [7:0] CHR_FF     = 8'h0C;
    localparam logic [7:0] CHR_LF     = 8'h0A;
    localparam logic [7:0] CHR_CR     = 8'h0D;
    localparam logic [7:0] CHR_TAB    = 8'h09;

    // Upper 22 bits of a high surrogate (0xD800 to 0xDBFF).
    localparam logic [21:0] HIGH_TOP = 22'h36;

    // Up to four bytes of one piece of output.
    typedef struct packed {
        logic [3:0][7:0] b;
        logic [2:0]      n;
    } t_chunk;

    // Bytes collected so far for the current request.
    typedef struct packed {
        logic [bsed_pkg::OUT_MAX-1:0][7:0] b;
        logic [3:0]                        n;
    } t_acc;

    // Hex digit value with a valid flag on top.
    function automatic logic [4:0] hex_of(input logic [7:0] c);
        logic [4:0] r;
        r = '0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

    // A chunk of a single byte.
    function automatic t_chunk one_byte(input logic [7:0] c);
        t_chunk r;
        r = '0;
        r.b[0] = c;
        r.n = 3'd1;
        return r;
    endfunction

    // UTF-8 encoding of a code point; surrogates and out-of-range values give '?'.
    function automatic t_chunk utf8_of(input logic [31:0] c);
        t_chunk r;
        r = '0;
        if (c < 32'h80) begin
            r.b[0] = c[7:0];
            r.n = 3'd1;
        end else if (c < 32'h800) begin
            r.b[0] = {3'b110, c[10:6]};
            r.b[1] = {2'b10, c[5:0]};
            r.n = 3'd2;
        end else if (c >= 32'hD800 && c <= 32'hDFFF) begin
            r.b[0] = CHR_QMARK;
            r.n = 3'd1;
        end else if (c < 32'h10000) begin
            r.b[0] = {4'b1110, c[15:12]};
            r.b[1] = {2'b10, c[11:6]};
            r.b[2] = {2'b10, c[5:0]};
            r.n = 3'd3;
        end else if (c <= 32'h10FFFF) begin
            r.b[0] = {5'b11110, c[20:18]};
            r.b[1] = {2'b10, c[17:12]};
            r.b[2] = {2'b10, c[11:6]};
            r.b[3] = {2'b10, c[5:0]};
            r.n = 3'd4;
        end else begin
            r.b[0] = CHR_QMARK;
            r.n = 3'd1;
        end
        return r;
    endfunction

    // Appends a chunk behind the bytes already collected; overflow is dropped.
    function automatic t_acc add_chunk(input t_acc a, input t_chunk c);
        t_acc       r;
        logic [3:0] off;
        r = a;
        for (int p = 0; p < bsed_pkg::OUT_MAX; p++) begin
            off = 4'(p) - a.n;
            if (4'(p) >= a.n && off < 4'(c.n)) begin
                r.b[p] = c.b[off[1:0]];
            end
        end
        r.n = a.n + 4'(c.n);
        return r;
    endfunction

    logic [3:0]  r_mode, n_mode;
    logic [3:0]  r_digits, n_digits;
    logic [31:0] r_accum, n_accum;
    logic        r_brace, n_brace;
    logic [9:0]  r_high, n_high;

    logic [7:0]  in_b;
    logic [4:0]  hx;
    logic        hv;
    logic [3:0]  hd;
    logic        pre_q;
    logic        c_emit;
    logic        d_emit;
    logic        e_emit;
    logic        d_byte_v;
    logic [7:0]  d_byte;
    logic        go_d;
    logic [31:0] emit_val;
    logic [3:0]  dl_dec;
    t_chunk      e_fix;
    t_chunk      code_bytes;
    t_acc        acc;

    assign in_b = i_item.in_byte;
    assign hx   = hex_of(in_b);
    assign hv   = hx[4];
    assign hd   = hx[3:0];

    // Parse the request byte and work out the next state and the bytes produced.
    always_comb begin
        n_mode   = r_mode;
        n_digits = r_digits;
        n_accum  = r_accum;
        n_brace  = r_brace;
        n_high   = r_high;
        pre_q    = 1'b0;
        c_emit   = 1'b0;
        d_emit   = 1'b0;
        e_emit   = 1'b0;
        d_byte_v = 1'b0;
        d_byte   = CHR_NUL;
        go_d     = 1'b1;
        emit_val = '0;
        e_fix    = '0;
        dl_dec   = '0;

        // A failed surrogate lookahead gives '?' and replays the held bytes.
        unique case (n_mode)
            MODE_LA0: begin
                if (in_b != CHR_BSL) begin
                    pre_q  = 1'b1;
                    n_mode = MODE_PLAIN;
                end
            end
            MODE_LA1: begin
                if (in_b != CHR_LC_U) begin
                    pre_q  = 1'b1;
                    n_mode = MODE_BSL;
                end
            end
            MODE_LA2: begin
                if (in_b != CHR_LC_D && in_b != CHR_UC_D) begin
                    pre_q    = 1'b1;
                    n_mode   = MODE_OPEN;
                    n_digits = 4'd4;
                    n_accum  = '0;
                    n_brace  = 1'b0;
                end
            end
            MODE_LA3: begin
                if (!(hv && hd >= 4'hC)) begin
                    pre_q    = 1'b1;
                    n_mode   = MODE_DIGITS;
                    n_digits = 4'd3;
                    n_accum  = 32'hD;
                    n_brace  = 1'b0;
                end
            end
            MODE_LOW: begin
                if (!hv) begin
                    pre_q  = 1'b1;
                    n_mode = MODE_PLAIN;
                end
            end
            default: begin
            end
        endcase

        // Without an opening brace the byte is already the first digit.
        if (n_mode == MODE_OPEN && in_b != CHR_LBRACE) begin
            n_mode = MODE_DIGITS;
        end

        // A byte that is not a digit ends the code.
        if ((n_mode == MODE_DIGITS && !hv) || n_mode == MODE_CLOSE) begin
            if (n_brace && in_b == CHR_RBRACE) begin
                go_d = 1'b0;
                if (n_accum[31:10] == HIGH_TOP) begin
                    n_high = n_accum[9:0];
                    n_mode = MODE_LA0;
                end else begin
                    c_emit   = 1'b1;
                    emit_val = n_accum;
                    n_mode   = MODE_PLAIN;
                end
            end else if (n_accum[31:10] == HIGH_TOP && in_b == CHR_BSL) begin
                go_d   = 1'b0;
                n_high = n_accum[9:0];
                n_mode = MODE_LA1;
            end else begin
                c_emit   = 1'b1;
                emit_val = n_accum;
                n_mode   = MODE_PLAIN;
            end
        end

        // Regular handling of the byte in the state reached so far.
        if (go_d) begin
            dl_dec = (n_digits != 4'd0) ? n_digits - 4'd1 : n_digits;
            unique case (n_mode)
                MODE_BSL: begin
                    n_mode  = MODE_PLAIN;
                    n_accum = '0;
                    n_brace = 1'b0;
                    unique case (in_b)
                        CHR_NUL: begin
                        end
                        CHR_LC_B: begin
                            d_byte_v = 1'b1;
                            d_byte   = CHR_BS;
                        end
                        CHR_LC_E: begin
                            d_byte_v = 1'b1;
                            d_byte   = CHR_ESC;
                        end
                        CHR_LC_F: begin
                            d_byte_v = 1'b1;
                            d_byte   = CHR_FF;
                        end
                        CHR_LC_N: begin
                            d_byte_v = 1'b1;
                            d_byte   = CHR_LF;
                        end
                        CHR_LC_R: begin
                            d_byte_v = 1'b1;
                            d_byte   = CHR_CR;
                        end
                        CHR_LC_T: begin
                            d_byte_v = 1'b1;
                            d_byte   = CHR_TAB;
                        end
                        CHR_LC_X: begin
                            n_mode   = MODE_OPEN;
                            n_digits = 4'd2;
                        end
                        CHR_LC_U: begin
                            n_mode   = MODE_OPEN;
                            n_digits = 4'd4;
                        end
                        CHR_UC_U: begin
                            n_mode   = MODE_OPEN;
                            n_digits = 4'd8;
                        end
                        default: begin
                            d_byte_v = 1'b1;
                            d_byte   = in_b;
                        end
                    endcase
                end
                MODE_OPEN: begin
                    n_brace  = 1'b1;
                    n_digits = 4'd8;
                    n_mode   = MODE_DIGITS;
                end
                MODE_DIGITS: begin
                    n_accum  = {n_accum[27:0], hd};
                    n_digits = dl_dec;
                    if (dl_dec == 4'd0) begin
                        if (n_brace) begin
                            n_mode = MODE_CLOSE;
                        end else if (n_accum[31:10] == HIGH_TOP) begin
                            n_high = n_accum[9:0];
                            n_mode = MODE_LA0;
                        end else begin
                            d_emit   = 1'b1;
                            emit_val = n_accum;
                            n_mode   = MODE_PLAIN;
                        end
                    end
                end
                MODE_CLOSE: begin
                end
                MODE_LA0: begin
                    n_mode = MODE_LA1;
                end
                MODE_LA1: begin
                    n_mode = MODE_LA2;
                end
                MODE_LA2: begin
                    n_mode = MODE_LA3;
                end
                MODE_LA3: begin
                    n_accum  = {24'h0, 4'hD, hd};
                    n_digits = 4'd2;
                    n_mode   = MODE_LOW;
                end
                MODE_LOW: begin
                    n_accum  = {n_accum[27:0], hd};
                    n_digits = dl_dec;
                    if (dl_dec == 4'd0) begin
                        d_emit   = 1'b1;
                        emit_val = 32'h0001_0000 + {12'h0, n_high, n_accum[9:0]};
                        n_mode   = MODE_PLAIN;
                    end
                end
                default: begin
                    if (in_b == CHR_BSL) begin
                        n_mode = MODE_BSL;
                    end else begin
                        d_byte_v = 1'b1;
                        d_byte   = in_b;
                        n_mode   = MODE_PLAIN;
                    end
                end
            endcase
        end

        // End of string: settle whatever is still pending.
        if (i_item.end_of_string) begin
            unique case (n_mode) inside
                MODE_OPEN: begin
                    e_emit   = 1'b1;
                    emit_val = '0;
                end
                MODE_DIGITS, MODE_CLOSE: begin
                    e_emit   = 1'b1;
                    emit_val = n_accum;
                end
                MODE_LA0, MODE_LA1, MODE_LOW: begin
                    e_fix = one_byte(CHR_QMARK);
                end
                MODE_LA2: begin
                    e_fix.b[0] = CHR_QMARK;
                    e_fix.b[1] = CHR_NUL;
                    e_fix.n    = 3'd2;
                end
                MODE_LA3: begin
                    e_fix.b[0] = CHR_QMARK;
                    e_fix.b[1] = CHR_CR;
                    e_fix.n    = 3'd2;
                end
                default: begin
                end
            endcase
            n_mode = MODE_PLAIN;
        end

        // At most one code point is encoded per request.
        code_bytes = utf8_of(emit_val);

        // Collect the pieces in output order.
        acc = '0;
        if (pre_q) begin
            acc = add_chunk(acc, one_byte(CHR_QMARK));
        end
        if (c_emit) begin
            acc = add_chunk(acc, code_bytes);
        end
        if (d_byte_v) begin
            acc = add_chunk(acc, one_byte(d_byte));
        end
        if (d_emit) begin
            acc = add_chunk(acc, code_bytes);
        end
        acc = add_chunk(acc, e_fix);
        if (e_emit) begin
            acc = add_chunk(acc, code_bytes);
        end
    end

    // Burst handed to the queue; the count saturates at the burst size.
    always_comb begin
        o_burst.bytes = acc.b;
        if (acc.n > 4'(bsed_pkg::OUT_MAX)) begin
            o_burst.count = bsed_pkg::CNT_W'(bsed_pkg::OUT_MAX);
        end else begin
            o_burst.count = bsed_pkg::CNT_W'(acc.n);
        end
    end

    assign o_has = (acc.n != 4'd0);

    // Parser state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_PLAIN;
            r_digits <= '0;
            r_accum  <= '0;
            r_brace  <= 1'b0;
            r_high   <= '0;
        end else if (i_accept) begin
            r_mode   <= n_mode;
            r_digits <= n_digits;
            r_accum  <= n_accum;
            r_brace  <= n_brace;
            r_high   <= n_high;
        end
    end

endmodule

FILE: hdl/bsed_queue.sv
// Short queue of bursts between the parser front end and the byte back end.
module bsed_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  bsed_pkg::t_burst i_data,
    output logic             o_full,
    input  logic             i_pop,
    output bsed_pkg::t_burst o_data,
    output logic             o_empty
);

    localparam int PTR_W = $clog2(bsed_pkg::QUEUE_DEPTH);

    bsed_pkg::t_burst r_mem [bsed_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W:0]   r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == (PTR_W + 1)'(bsed_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Storage is written at the tail; pointers wrap with the power-of-two depth.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + (PTR_W + 1)'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - (PTR_W + 1)'(1);
            end
        end
    end

endmodule

FILE: hdl/bsed_back.sv
// Back end: hands out the bytes of one burst at a time, one byte per cycle while popped.
module bsed_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_avail,
    input  bsed_pkg::t_burst    i_burst,
    output logic                o_take,
    output bsed_pkg::t_out_item o_item,
    output logic                o_empty,
    input  logic                i_pop
);

    bsed_pkg::t_burst             r_burst;
    logic [bsed_pkg::IDX_W-1:0]   r_idx;
    logic                         r_valid;
    logic                         last;
    logic                         popped;

    assign last   = (r_idx == bsed_pkg::IDX_W'(r_burst.count - bsed_pkg::CNT_W'(1)));
    assign popped = i_pop && r_valid;
    assign o_take = i_avail && (!r_valid || (popped && last));

    assign o_empty         = !r_valid;
    assign o_item.out_byte = r_burst.bytes[r_idx];
    assign o_item.run_last = last;

    // Load the next burst when the current one is done, else step through it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (o_take) begin
            r_valid <= 1'b1;
            r_idx   <= '0;
        end else if (popped) begin
            if (last) begin
                r_valid <= 1'b0;
            end else begin
                r_idx <= r_idx + bsed_pkg::IDX_W'(1);
            end
        end
    end

    // Burst payload.
    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_burst <= i_burst;
        end
    end

endmodule

FILE: hdl/backslash_escape_decoder_unit.sv
// Top level of the backslash escape decoder.
// Usage: raw string bytes enter as requests on the input queue port (push, full);
// a request is taken at a clock edge with push high and full low. Each request
// carries one byte and an end-of-string flag. Decoded bytes leave on the output
// queue port (empty, pop): the oldest byte is shown while empty is low and is
// taken at a clock edge with pop high. run_last marks the last byte that one
// request produced; a request may produce no byte at all, or up to five.
// The burst of a taken request is written into the burst queue and then loaded
// into the back end register, whose first byte is then shown. Throughput: one
// request per cycle while the four-entry burst queue has room; the back end sends
// one byte per cycle while pop is high, so the queue can fill during multi-byte
// runs. A receiver that stalls lets the queue fill, after which full rises and
// input stops; nothing is lost. Reset (synchronous, active low) empties the
// queue and the output stage and returns the parser to plain copy mode.
module backslash_escape_decoder_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  bsed_pkg::t_in_item  i_in_item,
    output logic                empty,
    input  logic                pop,
    output bsed_pkg::t_out_item o_out_item
);

    logic             accept;
    logic             front_has;
    logic             q_empty;
    logic             q_pop;
    bsed_pkg::t_burst front_burst;
    bsed_pkg::t_burst q_burst;

    assign accept = push && !full;

    // Parser front end.
    bsed_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(accept),
        .i_item  (i_in_item),
        .o_burst (front_burst),
        .o_has   (front_has)
    );

    // Burst queue; requests that produce nothing are not stored.
    bsed_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (accept && front_has),
        .i_data (front_burst),
        .o_full (full),
        .i_pop  (q_pop),
        .o_data (q_burst),
        .o_empty(q_empty)
    );

    // Byte output back end.
    bsed_back u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_avail(!q_empty),
        .i_burst(q_burst),
        .o_take (q_pop),
        .o_item (o_out_item),
        .o_empty(empty),
        .i_pop  (pop)
    );

endmodule

FILE: hdl/bsed_checker.sv
// Port-level checks of the escape decoder, bound to its top level.
`include "backslash_escape_decoder_unit_macros.svh"

module bsed_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                push,
    input logic                full,
    input logic                empty,
    input logic                pop,
    input bsed_pkg::t_out_item o_out_item
);

    // Leaving reset, no byte waits and input is open.
    `BSED_ASSERT_IMPL(a_reset_clear, i_clk, i_rst_n, $past(!i_rst_n), empty && !full, "state not clear after reset")

    // A waiting byte that is not taken stays in place.
    `BSED_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, !empty && !pop, !empty && $stable(o_out_item), "output changed while stalled")

    // The bytes of one request come out without a gap.
    `BSED_ASSERT_NEXT(a_burst_gapless, i_clk, i_rst_n, !empty && pop && !o_out_item.run_last, !empty, "gap inside a burst")

    // The queue can only become full after a request was taken.
    `BSED_ASSERT_IMPL(a_full_cause, i_clk, i_rst_n, $rose(full), $past(push), "full rose without a request")

endmodule

bind backslash_escape_decoder_unit bsed_checker u_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .push      (push),
    .full      (full),
    .empty     (empty),
    .pop       (pop),
    .o_out_item(o_out_item)
);

FILE: dv/tb.sv
// Self-checking bench for the escape decoder: directed rows, then random escaped strings.
`timescale 1ns / 100ps

module tb;

    // Character codes that steer the unescaper.
    localparam logic [7:0] CH_BSL    = 8'h5C;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_B = 8'h62, CH_E = 8'h65, CH_F = 8'h66, CH_N = 8'h6E;
    localparam logic [7:0] CH_R = 8'h72, CH_T = 8'h74, CH_X = 8'h78, CH_U = 8'h75;
    localparam logic [7:0] CH_UU = 8'h55, CH_D = 8'h64, CH_DD = 8'h44;

    typedef enum logic [3:0] {
        PM_PLAIN, PM_BSL, PM_OPEN, PM_DIGITS, PM_CLOSE,
        PM_LA0, PM_LA1, PM_LA2, PM_LA3, PM_LOW
    } t_parse_mode;

    // One directed row: a request and, where obvious, the single byte it gives.
    typedef struct packed {
        bsed_pkg::t_in_item req;
        logic               typed;
        logic [2:0]         n_out;
        logic [7:0]         out0;
    } t_dir_row;

    logic                i_clk;
    logic                i_rst_n;
    logic                push;
    logic                full;
    bsed_pkg::t_in_item  i_in_item;
    logic                empty;
    logic                pop;
    bsed_pkg::t_out_item o_out_item;

    // Unescaper state, kept in step with every accepted request.
    t_parse_mode pmode;
    logic [3:0]  digs_left;
    logic [31:0] code_acc;
    logic        brace_on;
    logic [31:0] high_cp;
    logic [7:0]  redo_q[$];
    logic [7:0]  utf8_q[$];

    // Decoded bytes still to come out of the block, oldest first.
    bsed_pkg::t_out_item pending[$];
    bsed_pkg::t_out_item head_byte;
    logic [7:0] tok_q[$];
    t_dir_row   dir_rows [29];
    int         err_count;
    int         n_sent;
    int         burst_left;
    logic       hold_rx;

    backslash_escape_decoder_unit DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_in_item  (i_in_item),
        .empty      (empty),
        .pop        (pop),
        .o_out_item (o_out_item)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void flag_error(input string msg);
        err_count++;
        if (err_count <= 10) $display("%s", msg);
    endfunction

    function automatic void put_byte(input logic [7:0] b);
        if (utf8_q.size() < 8) utf8_q.push_back(b);
    endfunction

    function automatic int hex_value(input logic [7:0] b);
        if (b >= 8'h30 && b <= 8'h39) return int'(b) - 'h30;
        if (b >= 8'h61 && b <= 8'h66) return int'(b) - 'h61 + 10;
        if (b >= 8'h41 && b <= 8'h46) return int'(b) - 'h41 + 10;
        return -1;
    endfunction

    function automatic bit is_high_half(input logic [31:0] c);
        return c >= 32'hD800 && c < 32'hDC00;
    endfunction

    // UTF-8 encoding; surrogates and values past the last plane become '?'.
    function automatic void emit_utf8(input logic [31:0] c);
        if (c < 32'h80) begin
            put_byte(c[7:0]);
        end else if (c < 32'h800) begin
            put_byte({3'b110, c[10:6]});
            put_byte({2'b10, c[5:0]});
        end else if (c >= 32'hD800 && c <= 32'hDFFF) begin
            put_byte(CH_QMARK);
        end else if (c < 32'h10000) begin
            put_byte({4'b1110, c[15:12]});
            put_byte({2'b10, c[11:6]});
            put_byte({2'b10, c[5:0]});
        end else if (c <= 32'h10FFFF) begin
            put_byte({5'b11110, c[20:18]});
            put_byte({2'b10, c[17:12]});
            put_byte({2'b10, c[11:6]});
            put_byte({2'b10, c[5:0]});
        end else begin
            put_byte(CH_QMARK);
        end
    endfunction

    // A finished code either waits for a low half or goes out now.
    function automatic void finish_code();
        if (is_high_half(code_acc)) begin
            high_cp = code_acc;
            pmode   = PM_LA0;
        end else begin
            emit_utf8(code_acc);
            pmode = PM_PLAIN;
        end
    endfunction

    // A code cut short by a byte that is not one of its digits.
    function automatic void code_cut(input logic [7:0] b);
        if (brace_on && b == CH_RBRACE) begin
            finish_code();
        end else if (is_high_half(code_acc) && b == CH_BSL) begin
            high_cp = code_acc;
            pmode   = PM_LA1;
        end else begin
            emit_utf8(code_acc);
            pmode = PM_PLAIN;
            redo_q.push_front(b);
        end
    endfunction

    // Pairing failed: '?' for the high half, then the held bytes run again.
    function automatic void unpair(input int held, input bit with_b, input logic [7:0] b);
        put_byte(CH_QMARK);
        pmode = PM_PLAIN;
        if (with_b) redo_q.push_front(b);
        if (held >= 3) redo_q.push_front(CH_D);
        if (held >= 2) redo_q.push_front(CH_U);
        if (held >= 1) redo_q.push_front(CH_BSL);
    endfunction

    function automatic void parse_byte(input logic [7:0] b);
        int h;
        h = hex_value(b);
        case (pmode)
            PM_BSL: begin
                pmode = PM_PLAIN;
                case (b)
                    8'h00: ;
                    CH_B: put_byte(8'h08);
                    CH_E: put_byte(8'h1B);
                    CH_F: put_byte(8'h0C);
                    CH_N: put_byte(8'h0A);
                    CH_R: put_byte(8'h0D);
                    CH_T: put_byte(8'h09);
                    CH_X: begin pmode = PM_OPEN; digs_left = 4'd2; end
                    CH_U: begin pmode = PM_OPEN; digs_left = 4'd4; end
                    CH_UU: begin pmode = PM_OPEN; digs_left = 4'd8; end
                    default: put_byte(b);
                endcase
                code_acc = '0;
                brace_on = 1'b0;
            end
            PM_OPEN: begin
                pmode = PM_DIGITS;
                if (b == CH_LBRACE) begin
                    brace_on  = 1'b1;
                    digs_left = 4'd8;
                end else begin
                    redo_q.push_front(b);
                end
            end
            PM_DIGITS: begin
                if (h < 0) begin
                    code_cut(b);
                end else begin
                    code_acc = {code_acc[27:0], h[3:0]};
                    if (digs_left > 0) digs_left--;
                    if (digs_left == 0) begin
                        if (brace_on) pmode = PM_CLOSE;
                        else finish_code();
                    end
                end
            end
            PM_CLOSE: code_cut(b);
            PM_LA0: begin
                if (b == CH_BSL) pmode = PM_LA1;
                else unpair(0, 1'b1, b);
            end
            PM_LA1: begin
                if (b == CH_U) pmode = PM_LA2;
                else unpair(1, 1'b1, b);
            end
            PM_LA2: begin
                if (b == CH_D || b == CH_DD) pmode = PM_LA3;
                else unpair(2, 1'b1, b);
            end
            PM_LA3: begin
                if (h >= 12) begin
                    code_acc  = 32'hD0 | 32'(h);
                    digs_left = 4'd2;
                    pmode     = PM_LOW;
                end else begin
                    unpair(3, 1'b1, b);
                end
            end
            PM_LOW: begin
                if (h < 0) begin
                    put_byte(CH_QMARK);
                    pmode = PM_PLAIN;
                    redo_q.push_front(b);
                end else begin
                    code_acc = {code_acc[27:0], h[3:0]};
                    if (digs_left > 0) digs_left--;
                    if (digs_left == 0) begin
                        emit_utf8(((high_cp - 32'hD800) << 10) + (code_acc - 32'hDC00)
                                  + 32'h10000);
                        pmode = PM_PLAIN;
                    end
                end
            end
            default: begin
                pmode = PM_PLAIN;
                if (b == CH_BSL) pmode = PM_BSL;
                else put_byte(b);
            end
        endcase
    endfunction

    function automatic void drain_redo();
        while (redo_q.size() > 0) parse_byte(redo_q.pop_front());
    endfunction

    // Bytes that one request yields; the string end settles any open work.
    function automatic void decode_request(input bsed_pkg::t_in_item req);
        utf8_q.delete();
        redo_q.delete();
        redo_q.push_back(req.in_byte);
        drain_redo();
        if (req.end_of_string) begin
            case (pmode)
                PM_LA0: unpair(0, 1'b0, 8'h00);
                PM_LA1: unpair(1, 1'b0, 8'h00);
                PM_LA2: unpair(2, 1'b0, 8'h00);
                PM_LA3: unpair(3, 1'b0, 8'h00);
                default: ;
            endcase
            drain_redo();
            case (pmode)
                PM_OPEN: emit_utf8(32'h0);
                PM_DIGITS, PM_CLOSE: emit_utf8(code_acc);
                PM_LOW: put_byte(CH_QMARK);
                default: ;
            endcase
            pmode = PM_PLAIN;
        end
    endfunction

    function automatic t_dir_row dir_row(input logic [7:0] b, input logic eos,
                                         input logic typed, input int n,
                                         input logic [7:0] out0);
        t_dir_row r;
        r.req.in_byte       = b;
        r.req.end_of_string = eos;
        r.typed             = typed;
        r.n_out             = 3'(n);
        r.out0              = out0;
        return r;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 10) return 8'h30 + 8'(v);
        if ($urandom_range(0, 1) == 0) return 8'h41 + 8'(v) - 8'd10;
        return 8'h61 + 8'(v) - 8'd10;
    endfunction

    function automatic void add_hex(input logic [31:0] v, input int n);
        for (int i = n - 1; i >= 0; i--) tok_q.push_back(hex_char(v[4*i +: 4]));
    endfunction

    // Code points spread over every UTF-8 length, surrogates and out of range.
    function automatic logic [31:0] pick_code(input int n);
        logic [31:0] v;
        case ($urandom_range(0, 5))
            0: v = $urandom_range(0, 'h7F);
            1: v = $urandom_range('h80, 'h7FF);
            2: v = $urandom_range('h800, 'hFFFF);
            3: v = $urandom_range('h10000, 'h10FFFF);
            4: v = $urandom_range('hD800, 'hDFFF);
            default: v = $urandom;
        endcase
        if (n < 8) v = v & ((32'h1 << (4 * n)) - 1);
        return v;
    endfunction

    // One random piece of an escaped string, mostly well formed.
    function automatic void build_token();
        int kind, ndig, n, cut;
        logic [7:0] b;
        logic [31:0] hi, lo;
        logic brace;
        tok_q.delete();
        kind = $urandom_range(0, 99);
        if (kind < 30) begin
            b = 8'($urandom_range(0, 255));
            tok_q.push_back(b == CH_BSL ? CH_N : b);
        end else if (kind < 45) begin
            tok_q.push_back(CH_BSL);
            case ($urandom_range(0, 7))
                0: tok_q.push_back(CH_B);
                1: tok_q.push_back(CH_E);
                2: tok_q.push_back(CH_F);
                3: tok_q.push_back(CH_N);
                4: tok_q.push_back(CH_R);
                5: tok_q.push_back(CH_T);
                default: tok_q.push_back(8'($urandom_range(0, 255)));
            endcase
        end else if (kind < 75) begin
            tok_q.push_back(CH_BSL);
            case ($urandom_range(0, 2))
                0: begin tok_q.push_back(CH_X); ndig = 2; end
                1: begin tok_q.push_back(CH_U); ndig = 4; end
                default: begin tok_q.push_back(CH_UU); ndig = 8; end
            endcase
            brace = ($urandom_range(0, 2) == 0);
            if (brace) tok_q.push_back(CH_LBRACE);
            n = brace ? $urandom_range(1, 8) : ndig;
            if ($urandom_range(0, 5) == 0) n = $urandom_range(0, ndig);
            add_hex(pick_code(n), n);
            if (brace && $urandom_range(0, 4) != 0) tok_q.push_back(CH_RBRACE);
        end else if (kind < 92) begin
            hi = 32'hD800 + $urandom_range(0, 'h3FF);
            lo = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 'hFFFF)
                                             : 32'hDC00 + $urandom_range(0, 'h3FF);
            tok_q.push_back(CH_BSL);
            tok_q.push_back(CH_U);
            add_hex(hi, 4);
            if ($urandom_range(0, 7) != 0) begin
                tok_q.push_back(CH_BSL);
                tok_q.push_back(CH_U);
                add_hex(lo, 4);
            end
            // Broken pairs: cut anywhere inside the second escape.
            if ($urandom_range(0, 3) == 0 && tok_q.size() > 6) begin
                cut = $urandom_range(6, tok_q.size() - 1);
                while (tok_q.size() > cut) void'(tok_q.pop_back());
            end
        end else begin
            repeat ($urandom_range(1, 3)) tok_q.push_back(8'($urandom_range(0, 255)));
        end
    endfunction

    // Offer one request in random bursts, then record what it should yield.
    task automatic offer_request(input t_dir_row r);
        int gap, n;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        push      <= 1'b1;
        i_in_item <= r.req;
        do @(posedge i_clk); while (full);
        n_sent++;
        decode_request(r.req);
        if (r.typed) begin
            if (r.n_out != 0) pending.push_back('{out_byte: r.out0, run_last: 1'b1});
        end else begin
            n = (utf8_q.size() > bsed_pkg::OUT_MAX) ? bsed_pkg::OUT_MAX : utf8_q.size();
            for (int k = 0; k < n; k++)
                pending.push_back('{out_byte: utf8_q[k], run_last: (k == n - 1)});
        end
    endtask

    // Stimulus: reset, directed rows, random strings, then drain.
    initial begin
        int waited;
        bit eos;
        push       = 1'b0;
        i_in_item  = '0;
        i_rst_n    = 1'b0;
        err_count  = 0;
        n_sent     = 0;
        burst_left = 0;
        pmode      = PM_PLAIN;
        digs_left  = '0;
        code_acc   = '0;
        brace_on   = 1'b0;
        high_cp    = '0;
        dir_rows = '{
            dir_row(8'h00,  1'b0, 1'b1, 1, 8'h00),
            dir_row(8'hFF,  1'b1, 1'b1, 1, 8'hFF),
            dir_row(CH_BSL, 1'b1, 1'b1, 0, 8'h00),
            dir_row(CH_BSL, 1'b0, 1'b1, 0, 8'h00),
            dir_row(8'h00,  1'b0, 1'b1, 0, 8'h00),
            dir_row(CH_BSL, 1'b0, 1'b1, 0, 8'h00),
            dir_row(CH_N,   1'b0, 1'b1, 1, 8'h0A),
            dir_row(CH_BSL, 1'b0, 1'b0, 0, 8'h00),
            dir_row(CH_X,   1'b0, 1'b0, 0, 8'h00),
            dir_row("g",    1'b0, 1'b0, 0, 8'h00),
            dir_row(CH_BSL, 1'b0, 1'b0, 0, 8'h00),
            dir_row(CH_U,   1'b0, 1'b0, 0, 8'h00),
            dir_row(CH_DD,  1'b0, 1'b0, 0, 8'h00),
            dir_row("B",    1'b0, 1'b0, 0, 8'h00),
            dir_row("f",    1'b0, 1'b0, 0, 8'h00),
            dir_row("f",    1'b0, 1'b0, 0, 8'h00),
            dir_row(CH_BSL, 1'b0, 1'b0, 0, 8'h00),
            dir_row(CH_U,   1'b0, 1'b0, 0, 8'h00),
            dir_row(CH_DD,  1'b0, 1'b0, 0, 8'h00),
            dir_row("F",    1'b0, 1'b0, 0, 8'h00),
            dir_row("F",    1'b0, 1'b0, 0, 8'h00),
            dir_row("F",    1'b0, 1'b0, 0, 8'h00),
            dir_row(CH_BSL, 1'b0, 1'b0, 0, 8'h00),
            dir_row(CH_UU,  1'b0, 1'b0, 0, 8'h00),
            dir_row(CH_LBRACE, 1'b0, 1'b0, 0, 8'h00),
            dir_row("2",    1'b0, 1'b0, 0, 8'h00),
            dir_row("0",    1'b0, 1'b0, 0, 8'h00),
            dir_row("A",    1'b0, 1'b0, 0, 8'h00),
            dir_row("C",    1'b1, 1'b0, 0, 8'h00)
        };
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) offer_request(dir_rows[i]);

        // Random strings; the end mark mostly falls between escapes.
        while (n_sent < 460) begin
            build_token();
            foreach (tok_q[k]) begin
                eos = ((k == tok_q.size() - 1) && $urandom_range(0, 5) == 0)
                      || $urandom_range(0, 49) == 0;
                offer_request(dir_row(tok_q[k], eos, 1'b0, 0, 8'h00));
            end
        end
        push <= 1'b0;

        waited = 0;
        while (pending.size() != 0 && waited < 50000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (10) @(posedge i_clk);
        if (pending.size() != 0)
            flag_error($sformatf("%0d decoded bytes never arrived", pending.size()));
        if (err_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Receiver: stretches of free flow, light and heavy stalls.
    initial begin
        int mode, len;
        pop = 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            len  = $urandom_range(1, 40);
            repeat (len) begin
                @(posedge i_clk);
                case (mode)
                    0: pop <= !hold_rx;
                    1: pop <= !hold_rx && ($urandom_range(0, 3) != 0);
                    2: pop <= !hold_rx && ($urandom_range(0, 1) == 1);
                    default: pop <= !hold_rx && ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    // One long receiver hold-off while requests keep coming, to fill the block.
    initial begin
        hold_rx = 1'b0;
        wait (n_sent >= 120);
        @(posedge i_clk);
        hold_rx <= 1'b1;
        repeat (80) @(posedge i_clk);
        hold_rx <= 1'b0;
    end

    // Compare each decoded byte with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (pending.size() == 0) begin
                flag_error($sformatf("unexpected byte %h last %b",
                                     o_out_item.out_byte, o_out_item.run_last));
            end else begin
                head_byte = pending.pop_front();
                if (o_out_item.out_byte !== head_byte.out_byte
                    || o_out_item.run_last !== head_byte.run_last)
                    flag_error($sformatf("byte mismatch: expected %h last %b, got %h last %b",
                                         head_byte.out_byte, head_byte.run_last,
                                         o_out_item.out_byte, o_out_item.run_last));
            end
        end
    end

    initial begin
        #2000000;
        $display("status: fail");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hdl
hdl/bsed_pkg.sv
hdl/bsed_front.sv
hdl/bsed_queue.sv
hdl/bsed_back.sv
hdl/backslash_escape_decoder_unit.sv
hdl/bsed_checker.sv
dv/tb.sv
